>>> rtl/indexed_sequence_list_engine_assert.svh
// assertion macros used by indexed_sequence_list_engine.sv
`ifndef INDEXED_SEQUENCE_LIST_ENGINE_ASSERT_SVH
`define INDEXED_SEQUENCE_LIST_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// condition implies consequence in the same cycle
`define ISLE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("isle assertion failed");
// condition implies consequence in the next cycle
`define ISLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("isle assertion failed");
`else
`define ISLE_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ISLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/isle_pkg.sv
`default_nettype none

package isle_pkg;

    // width of the shift index broadcast to the cells (capacity up to 256)
    localparam int IDX_BITS = 8;

    // command codes, code seven is unused
    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_INSERT     = 3'd3,
        CMD_REMOVE     = 3'd4,
        CMD_READ       = 3'd5,
        CMD_CLEAR      = 3'd6
    } t_cmd;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

    // what the chain does this cycle
    typedef enum logic [1:0] {
        SH_HOLD   = 2'd0,
        SH_INSERT = 2'd1,
        SH_DELETE = 2'd2
    } t_shift;

    // control broadcast to every cell
    typedef struct packed {
        t_shift                op;
        logic [IDX_BITS-1:0]   idx;
    } t_cell_ctrl;

endpackage

`default_nettype wire

>>> rtl/isle_if.sv
`default_nettype none

// command channel
interface isle_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic [3:0]         position;
    logic signed [31:0] value;

    modport source (output valid, output command, output position, output value,
                    input ready);
    modport sink   (input valid, input command, input position, input value,
                    output ready);
endinterface

// result channel
interface isle_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] read_value;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [4:0]         count;
    logic               is_empty;
    logic [1:0]         status;

    modport source (output valid, output read_value, output front_value,
                    output back_value, output count, output is_empty, output status,
                    input ready);
    modport sink   (input valid, input read_value, input front_value,
                    input back_value, input count, input is_empty, input status,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/indexed_sequence_list_engine.sv
// channel   dir  payload                                          handshake
// i_cmd     in   command, position, value                         valid/ready
// o_res     out  read_value, front_value, back_value, count,      valid/ready
//                is_empty, status
//
// one command per cycle while each result is taken: the cell chain shifts at the
// accepting edge and the result is valid in the next cycle, held in the output register.
// a new command is taken when no result is held or while the held result is
// being taken, so a result that stalls holds the command side.
// reset clears the count, the status and the output valid; cell contents are not reset.
`default_nettype none
`include "indexed_sequence_list_engine_assert.svh"

module indexed_sequence_list_engine #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    isle_cmd_if.sink    i_cmd,
    isle_res_if.source  o_res
);
    import isle_pkg::*;

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (LEN_W > 4) ? LEN_W : 4;
    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

    // sign extend or cut a stored element to the 32-bit result field
    function automatic logic [31:0] f_widen(input logic [DATA_WIDTH-1:0] d);
        logic signed [DATA_WIDTH-1:0] s;
        s = d;
        return 32'(s);
    endfunction

    logic [LEN_W-1:0]       r_len;
    logic [LEN_W-1:0]       n_len;
    logic                   r_out_valid;
    logic [31:0]            r_rd;
    logic [31:0]            n_rd;
    t_status                r_status;
    t_status                n_status;
    t_cell_ctrl             w_ctrl;
    logic [DATA_WIDTH-1:0]  w_cells [CAPACITY];
    logic [DATA_WIDTH-1:0]  w_value;
    logic                   w_accept;
    logic                   w_full;
    logic                   w_empty;
    logic                   w_pos_ok;
    logic [CMP_W-1:0]       w_pos_c;
    logic [CMP_W-1:0]       w_len_c;
    t_cmd                   w_cmd;

    assign w_cmd    = t_cmd'(i_cmd.command);
    assign w_accept = i_cmd.valid && i_cmd.ready;
    assign w_full   = (r_len == CAP_LEN);
    assign w_empty  = (r_len == '0);
    assign w_pos_c  = CMP_W'(i_cmd.position);
    assign w_len_c  = CMP_W'(r_len);
    assign w_pos_ok = (w_pos_c < w_len_c);
    assign w_value  = DATA_WIDTH'($unsigned(i_cmd.value));

    // command decode into chain control, next count, read value and status
    always_comb begin
        w_ctrl.op  = SH_HOLD;
        w_ctrl.idx = '0;
        n_len      = r_len;
        n_rd       = '0;
        n_status   = ST_DONE;
        case (w_cmd)
            CMD_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctrl.op = SH_INSERT;
                    n_len     = r_len + 1'b1;
                end
            end
            CMD_PUSH_BACK: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctrl.op  = SH_INSERT;
                    w_ctrl.idx = IDX_BITS'(r_len);
                    n_len      = r_len + 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (w_empty) begin
                    n_status = ST_IGNORED;
                end else begin
                    w_ctrl.op = SH_DELETE;
                    n_len     = r_len - 1'b1;
                end
            end
            CMD_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctrl.op  = SH_INSERT;
                    w_ctrl.idx = w_pos_ok ? IDX_BITS'(i_cmd.position) : IDX_BITS'(r_len);
                    n_len      = r_len + 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (w_pos_ok) begin
                    w_ctrl.op  = SH_DELETE;
                    w_ctrl.idx = IDX_BITS'(i_cmd.position);
                    n_len      = r_len - 1'b1;
                end else begin
                    n_status = ST_IGNORED;
                end
            end
            CMD_READ: begin
                if (w_pos_ok) begin
                    n_rd = f_widen(w_cells[IDX_W'(i_cmd.position)]);
                end else begin
                    n_status = ST_IGNORED;
                end
            end
            CMD_CLEAR: n_len = '0;
            default:   n_status = ST_IGNORED;
        endcase
        if (!w_accept) begin
            w_ctrl.op = SH_HOLD;
        end
    end

    // row of cells, each shifting with its neighbors
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = w_cells[g];
        end else begin : g_mid_l
            assign w_left = w_cells[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_cells[g];
        end else begin : g_mid_r
            assign w_right = w_cells[g+1];
        end
        isle_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX        (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_value (w_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_cells[g])
        );
    end

    // count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_out_valid <= 1'b0;
            r_status    <= ST_DONE;
        end else begin
            if (w_accept) begin
                r_len       <= n_len;
                r_out_valid <= 1'b1;
                r_status    <= n_status;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // read value needs no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd <= n_rd;
        end
    end

    assign i_cmd.ready       = !r_out_valid || o_res.ready;
    assign o_res.valid       = r_out_valid;
    assign o_res.read_value  = r_rd;
    assign o_res.front_value = w_empty ? '0 : f_widen(w_cells[0]);
    assign o_res.back_value  = w_empty ? '0 : f_widen(w_cells[IDX_W'(r_len - 1'b1)]);
    assign o_res.count       = 5'(r_len);
    assign o_res.is_empty    = w_empty;
    assign o_res.status      = r_status;

    // checks
    `ISLE_ASSERT_SAME(a_len_bound, i_clk, i_rst_n, 1'b1, r_len <= CAP_LEN)
    `ISLE_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, w_accept && (w_cmd == CMD_CLEAR), r_len == '0)
    `ISLE_ASSERT_NEXT(a_full_holds, i_clk, i_rst_n, w_accept && w_full && (w_cmd == CMD_PUSH_BACK || w_cmd == CMD_PUSH_FRONT || w_cmd == CMD_INSERT), (r_len == $past(r_len)) && (r_status == ST_FULL))
    `ISLE_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, w_accept && !w_full && (w_cmd == CMD_PUSH_BACK), r_len == LEN_W'($past(r_len) + 1'b1))

endmodule

`default_nettype wire

>>> rtl/isle_cell.sv
`default_nettype none

module isle_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int IDX        = 0
) (
    input  wire logic                   i_clk,
    input  wire isle_pkg::t_cell_ctrl   i_ctrl,
    input  wire logic [DATA_WIDTH-1:0]  i_value,
    input  wire logic [DATA_WIDTH-1:0]  i_left,
    input  wire logic [DATA_WIDTH-1:0]  i_right,
    output logic      [DATA_WIDTH-1:0]  o_data
);
    import isle_pkg::*;

    localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(IDX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    // insert takes the left neighbor or the value, delete the right
    always_comb begin
        n_data = r_data;
        case (i_ctrl.op)
            SH_INSERT: begin
                if (MY_IDX > i_ctrl.idx) begin
                    n_data = i_left;
                end else if (MY_IDX == i_ctrl.idx) begin
                    n_data = i_value;
                end
            end
            SH_DELETE: begin
                if (MY_IDX >= i_ctrl.idx) begin
                    n_data = i_right;
                end
            end
            default: n_data = r_data;
        endcase
    end

    // element storage, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire
